/* hdl/tacu_pkg.sv */
// Shared types, codes and constants of the toroidal 3D automaton cell engine.
package tacu_pkg;

   localparam int CELL_W  = 3;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;
   localparam int CSR_DATA_W = 5;

   // Neighbours around one cell in three dimensions.
   localparam logic [COUNT_W-1:0] NBR_COUNT = COUNT_W'(26);

   localparam logic [CELL_W-1:0]  BIRTH_LEVEL_RESET = CELL_W'(4);
   localparam logic [COUNT_W-1:0] SURVIVE_MIN_RESET = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] SURVIVE_MAX_RESET = COUNT_W'(26);

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_COMPUTE = 2'd1,
      CMD_SWAP    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_BIRTH_LEVEL = 2'd0,
      CSR_SURVIVE_MIN = 2'd1,
      CSR_SURVIVE_MAX = 2'd2
   } csr_index_type;

   // Offset of a neighbour on one axis: one below, the same, one above.
   localparam logic [1:0] OFF_MINUS  = 2'd0;
   localparam logic [1:0] OFF_CENTRE = 2'd1;
   localparam logic [1:0] OFF_PLUS   = 2'd2;

   typedef struct packed {
      logic [1:0] oz;
      logic [1:0] oy;
      logic [1:0] ox;
   } offs_type;

   localparam offs_type OFFS_FIRST  = '{oz: OFF_MINUS, oy: OFF_MINUS, ox: OFF_MINUS};
   localparam offs_type OFFS_CENTRE = '{oz: OFF_CENTRE, oy: OFF_CENTRE, ox: OFF_CENTRE};

   // Plain base-3 increment of the offset triple, x fastest.
   function automatic offs_type offs_inc(input offs_type o);
      offs_type r;
      r = o;
      if (o.ox != OFF_PLUS) begin
         r.ox = o.ox + 2'd1;
      end else begin
         r.ox = OFF_MINUS;
         if (o.oy != OFF_PLUS) begin
            r.oy = o.oy + 2'd1;
         end else begin
            r.oy = OFF_MINUS;
            r.oz = (o.oz != OFF_PLUS) ? o.oz + 2'd1 : OFF_MINUS;
         end
      end
      return r;
   endfunction

   // Next neighbour offset; the cell itself is stepped over.
   function automatic offs_type offs_next(input offs_type o);
      offs_type r;
      r = offs_inc(o);
      if (r == OFFS_CENTRE) begin
         r = offs_inc(r);
      end
      return r;
   endfunction

endpackage

/* hdl/toroidal_3d_automaton_cell_update.sv */
// Top level of the toroidal 3D automaton cell engine.
//
// The engine keeps two banks of GRID_X x GRID_Y x GRID_Z 3-bit cells, one of them current.
// A write item stores a cell into the current bank and a swap item exchanges the banks;
// neither gives a result. A compute item reads the cell and its 26 wrapped neighbours from
// the current bank through that bank's single read port, one read a cycle, counts them with
// one compare unit, writes the next state into the other bank and returns one result item.
// A compute steps through accept, centre read, 26 neighbour reads, a drain of the last data
// and decide and write back; the result register frees the engine while the result waits,
// but a compute holds in its last step until an earlier result is taken. Write and compute
// items outside the grid, and command code 3, are dropped; swaps never are. Cells must be
// written before they are read; the banks are not cleared by reset. Configuration writes
// are always taken and must only be made while the engine is idle.
module toroidal_3d_automaton_cell_update
   import tacu_pkg::*;
#(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 32,
   parameter int GRID_Z = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x [4:0], pos_y [9:5], pos_z [14:10], cell_value [17:15], zero [23:18]
   input  logic [23:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_value [2:0], count_lower [7:3], count_same [12:8], zero [15:13]
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int XW = $clog2(GRID_X);
   localparam int YW = $clog2(GRID_Y);
   localparam int ZW = $clog2(GRID_Z);
   localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(GRID_X);
   localparam logic [ADDR_W-1:0] STRIDE_Z = ADDR_W'(GRID_X * GRID_Y);
   localparam logic [XW-1:0] X_LAST = XW'(GRID_X - 1);
   localparam logic [YW-1:0] Y_LAST = YW'(GRID_Y - 1);
   localparam logic [ZW-1:0] Z_LAST = ZW'(GRID_Z - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTRE,
      ST_NBR,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic bank_ff, bank_in;
   logic [CELL_W-1:0]  birth_level_ff, birth_level_in;
   logic [COUNT_W-1:0] survive_min_ff, survive_min_in;
   logic [COUNT_W-1:0] survive_max_ff, survive_max_in;

   // Wrapped coordinates below, at and above the addressed cell.
   logic [XW-1:0] xm_ff, xm_in, xc_ff, xc_in, xp_ff, xp_in;
   logic [YW-1:0] ym_ff, ym_in, yc_ff, yc_in, yp_ff, yp_in;
   logic [ZW-1:0] zm_ff, zm_in, zc_ff, zc_in, zp_ff, zp_in;
   logic [ADDR_W-1:0] ctr_addr_ff, ctr_addr_in;
   offs_type offs_ff, offs_in;
   logic [COUNT_W-1:0] nbr_cnt_ff, nbr_cnt_in;

   logic rd_vld_ff, rd_vld_in;
   logic rd_centre_ff, rd_centre_in;
   logic [CELL_W-1:0]  s_ff, s_in;
   logic [COUNT_W-1:0] lower_ff, lower_in;
   logic [COUNT_W-1:0] same_ff, same_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_next_ff, rsp_next_in;
   logic [COUNT_W-1:0] rsp_lower_ff, rsp_lower_in;
   logic [COUNT_W-1:0] rsp_same_ff, rsp_same_in;

   logic [POS_W-1:0]  req_x, req_y, req_z;
   logic [CELL_W-1:0] req_value;
   logic              req_in_grid;
   logic [XW-1:0]     req_xt;
   logic [YW-1:0]     req_yt;
   logic [ZW-1:0]     req_zt;
   logic [ADDR_W-1:0] req_addr;
   logic              req_fire;

   logic [XW-1:0] nx;
   logic [YW-1:0] ny;
   logic [ZW-1:0] nz;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data_a, rd_data_b, rd_data;

   logic              wr_en, wr_en_a, wr_en_b, wr_cur;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [CELL_W-1:0] next_value;
   logic              finish_go;

   assign req_x     = req_tdata[4:0];
   assign req_y     = req_tdata[9:5];
   assign req_z     = req_tdata[14:10];
   assign req_value = req_tdata[17:15];
   assign req_xt    = XW'(req_x);
   assign req_yt    = YW'(req_y);
   assign req_zt    = ZW'(req_z);
   assign req_in_grid = (int'(req_x) < GRID_X) && (int'(req_y) < GRID_Y)
                     && (int'(req_z) < GRID_Z);
   assign req_addr = ADDR_W'(req_xt) + ADDR_W'(req_yt) * STRIDE_Y
                   + ADDR_W'(req_zt) * STRIDE_Z;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Neighbour coordinate selection and its linear address.
   always_comb begin
      unique case (offs_ff.ox)
         OFF_MINUS: nx = xm_ff;
         OFF_PLUS:  nx = xp_ff;
         default:   nx = xc_ff;
      endcase
      unique case (offs_ff.oy)
         OFF_MINUS: ny = ym_ff;
         OFF_PLUS:  ny = yp_ff;
         default:   ny = yc_ff;
      endcase
      unique case (offs_ff.oz)
         OFF_MINUS: nz = zm_ff;
         OFF_PLUS:  nz = zp_ff;
         default:   nz = zc_ff;
      endcase
   end

   assign rd_addr = ADDR_W'(nx) + ADDR_W'(ny) * STRIDE_Y + ADDR_W'(nz) * STRIDE_Z;
   assign rd_data = bank_ff ? rd_data_b : rd_data_a;

   // Decision on the finished counts.
   always_comb begin
      logic lower_ok, same_ok;
      lower_ok = (lower_ff >= survive_min_ff) && (lower_ff <= survive_max_ff);
      same_ok  = (same_ff >= survive_min_ff) && (same_ff <= survive_max_ff);
      if (s_ff != '0) begin
         next_value = (lower_ok || same_ok) ? s_ff - CELL_W'(1) : '0;
      end else begin
         next_value = (lower_ff == COUNT_W'(birth_level_ff)) ? birth_level_ff : '0;
      end
   end

   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // One write port per bank: write items go to the current bank, results to the other.
   assign wr_cur  = req_fire && req_in_grid && (cmd_type'(req_tuser) == CMD_WRITE);
   assign wr_en   = wr_cur || finish_go;
   assign wr_addr = finish_go ? ctr_addr_ff : req_addr;
   assign wr_data = finish_go ? next_value : req_value;
   assign wr_en_a = wr_en && (finish_go ? bank_ff : !bank_ff);
   assign wr_en_b = wr_en && (finish_go ? !bank_ff : bank_ff);

   tacu_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_bank_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_a)
   );

   tacu_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_bank_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_b)
   );

   always_comb begin
      state_in       = state_ff;
      bank_in        = bank_ff;
      birth_level_in = birth_level_ff;
      survive_min_in = survive_min_ff;
      survive_max_in = survive_max_ff;
      xm_in = xm_ff; xc_in = xc_ff; xp_in = xp_ff;
      ym_in = ym_ff; yc_in = yc_ff; yp_in = yp_ff;
      zm_in = zm_ff; zc_in = zc_ff; zp_in = zp_ff;
      ctr_addr_in  = ctr_addr_ff;
      offs_in      = offs_ff;
      nbr_cnt_in   = nbr_cnt_ff;
      rd_vld_in    = 1'b0;
      rd_centre_in = 1'b0;
      s_in         = s_ff;
      lower_in     = lower_ff;
      same_in      = same_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_next_in  = rsp_next_ff;
      rsp_lower_in = rsp_lower_ff;
      rsp_same_in  = rsp_same_ff;

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIRTH_LEVEL: birth_level_in = csr_data[CELL_W-1:0];
            CSR_SURVIVE_MIN: survive_min_in = csr_data[COUNT_W-1:0];
            CSR_SURVIVE_MAX: survive_max_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end

      // The shared compare unit: one read item folded into the counts each cycle.
      if (rd_vld_ff) begin
         if (rd_centre_ff) begin
            s_in = rd_data;
         end else if (s_ff == '0) begin
            if (rd_data >= birth_level_ff) begin
               lower_in = lower_ff + COUNT_W'(1);
            end
         end else begin
            if (rd_data == s_ff - CELL_W'(1)) begin
               lower_in = lower_ff + COUNT_W'(1);
            end
            if (rd_data == s_ff) begin
               same_in = same_ff + COUNT_W'(1);
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd_type'(req_tuser))
                  CMD_SWAP: bank_in = !bank_ff;
                  CMD_COMPUTE: begin
                     if (req_in_grid) begin
                        xc_in = req_xt;
                        yc_in = req_yt;
                        zc_in = req_zt;
                        xm_in = (req_xt == '0) ? X_LAST : req_xt - XW'(1);
                        ym_in = (req_yt == '0) ? Y_LAST : req_yt - YW'(1);
                        zm_in = (req_zt == '0) ? Z_LAST : req_zt - ZW'(1);
                        xp_in = (req_xt == X_LAST) ? '0 : req_xt + XW'(1);
                        yp_in = (req_yt == Y_LAST) ? '0 : req_yt + YW'(1);
                        zp_in = (req_zt == Z_LAST) ? '0 : req_zt + ZW'(1);
                        ctr_addr_in = req_addr;
                        offs_in     = OFFS_CENTRE;
                        nbr_cnt_in  = '0;
                        lower_in    = '0;
                        same_in     = '0;
                        state_in    = ST_CENTRE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CENTRE: begin
            rd_vld_in    = 1'b1;
            rd_centre_in = 1'b1;
            offs_in      = OFFS_FIRST;
            state_in     = ST_NBR;
         end
         ST_NBR: begin
            rd_vld_in  = 1'b1;
            offs_in    = offs_next(offs_ff);
            nbr_cnt_in = nbr_cnt_ff + COUNT_W'(1);
            if (nbr_cnt_ff == NBR_COUNT - COUNT_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_go) begin
               rsp_valid_in = 1'b1;
               rsp_next_in  = next_value;
               rsp_lower_in = lower_ff;
               rsp_same_in  = same_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bank_ff        <= 1'b0;
         birth_level_ff <= BIRTH_LEVEL_RESET;
         survive_min_ff <= SURVIVE_MIN_RESET;
         survive_max_ff <= SURVIVE_MAX_RESET;
         rd_vld_ff      <= 1'b0;
         rd_centre_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         nbr_cnt_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         bank_ff        <= bank_in;
         birth_level_ff <= birth_level_in;
         survive_min_ff <= survive_min_in;
         survive_max_ff <= survive_max_in;
         rd_vld_ff      <= rd_vld_in;
         rd_centre_ff   <= rd_centre_in;
         rsp_valid_ff   <= rsp_valid_in;
         nbr_cnt_ff     <= nbr_cnt_in;
      end
      xm_ff <= xm_in; xc_ff <= xc_in; xp_ff <= xp_in;
      ym_ff <= ym_in; yc_ff <= yc_in; yp_ff <= yp_in;
      zm_ff <= zm_in; zc_ff <= zc_in; zp_ff <= zp_in;
      ctr_addr_ff  <= ctr_addr_in;
      offs_ff      <= offs_in;
      s_ff         <= s_in;
      lower_ff     <= lower_in;
      same_ff      <= same_in;
      rsp_next_ff  <= rsp_next_in;
      rsp_lower_ff <= rsp_lower_in;
      rsp_same_ff  <= rsp_same_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_same_ff, rsp_lower_ff, rsp_next_ff};

endmodule

/* hdl/tacu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tacu_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 32768,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/cell_update_checker.sv */
// Checker that predicts and compares the result items of the automaton cell engine.
`timescale 1ns / 1ps

module cell_update_checker
   import tacu_pkg::*;
#(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 32,
   parameter int GRID_Z = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [23:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatches,
   output int                    outstanding
);

   localparam int GRID_CELLS = GRID_X * GRID_Y * GRID_Z;

   // Packed so that next lands in the lowest bits, as on rsp_tdata.
   typedef struct packed {
      logic [COUNT_W-1:0] same;
      logic [COUNT_W-1:0] lower;
      logic [CELL_W-1:0]  next;
   } cell_verdict_type;

   logic [CELL_W-1:0]  grid [2][GRID_CELLS];
   logic               cur_bank;
   logic [CELL_W-1:0]  birth_lvl;
   logic [COUNT_W-1:0] survive_lo;
   logic [COUNT_W-1:0] survive_hi;
   cell_verdict_type   expected_cells [$];
   int                 fail_total;

   function automatic int cell_addr(input int x, input int y, input int z);
      return x + y * GRID_X + z * GRID_X * GRID_Y;
   endfunction

   function automatic bit survives(input int c);
      return (c >= survive_lo) && (c <= survive_hi);
   endfunction

   function automatic cell_verdict_type next_cell_state(input int x, input int y, input int z);
      cell_verdict_type  v;
      logic [CELL_W-1:0] s;
      logic [CELL_W-1:0] ns;
      int               nx, ny, nz, dx, dy, dz;
      int               lower, same;
      s = grid[cur_bank][cell_addr(x, y, z)];
      lower = 0;
      same = 0;
      for (dz = 0; dz < 3; dz++) begin
         nz = (z + GRID_Z - 1 + dz) % GRID_Z;
         for (dy = 0; dy < 3; dy++) begin
            ny = (y + GRID_Y - 1 + dy) % GRID_Y;
            for (dx = 0; dx < 3; dx++) begin
               nx = (x + GRID_X - 1 + dx) % GRID_X;
               if (!(dx == 1 && dy == 1 && dz == 1)) begin
                  ns = grid[cur_bank][cell_addr(nx, ny, nz)];
                  if (s == '0) begin
                     if (ns >= birth_lvl) lower++;
                  end else begin
                     if (ns == s - 3'd1) lower++;
                     if (ns == s) same++;
                  end
               end
            end
         end
      end
      if (s != '0) begin
         v.next = (survives(lower) || survives(same)) ? s - 3'd1 : '0;
      end else begin
         v.next = (lower == birth_lvl) ? birth_lvl : '0;
      end
      v.lower = lower[COUNT_W-1:0];
      v.same  = same[COUNT_W-1:0];
      return v;
   endfunction

   always @(posedge clock) begin
      cell_verdict_type want;
      cell_verdict_type got;
      int               x, y, z;
      if (reset) begin
         cur_bank   = 1'b0;
         birth_lvl  = BIRTH_LEVEL_RESET;
         survive_lo = SURVIVE_MIN_RESET;
         survive_hi = SURVIVE_MAX_RESET;
         expected_cells.delete();
         fail_total = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BIRTH_LEVEL: birth_lvl  = csr_data[CELL_W-1:0];
               CSR_SURVIVE_MIN: survive_lo = csr_data[COUNT_W-1:0];
               CSR_SURVIVE_MAX: survive_hi = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         // Results are matched before new items are predicted, so a result that comes
         // in the same cycle as a new item is paired with an older expectation.
         if (rsp_tvalid && rsp_tready) begin
            got = cell_verdict_type'(rsp_tdata[2*COUNT_W+CELL_W-1:0]);
            if (expected_cells.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("Unexpected result item: next_value %0d count_lower %0d count_same %0d",
                           got.next, got.lower, got.same);
            end else begin
               want = expected_cells.pop_front();
               if (got.next !== want.next || got.lower !== want.lower
                   || got.same !== want.same) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("Result mismatch: expected next_value %0d count_lower %0d %s%0d, %s",
                              want.next, want.lower, "count_same ", want.same,
                              $sformatf("got next_value %0d count_lower %0d count_same %0d",
                                        got.next, got.lower, got.same));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            x = int'(req_tdata[POS_W-1:0]);
            y = int'(req_tdata[2*POS_W-1:POS_W]);
            z = int'(req_tdata[3*POS_W-1:2*POS_W]);
            // A swap acts whatever its coordinates say.
            if (req_tuser == CMD_SWAP) begin
               cur_bank = ~cur_bank;
            end else if (x < GRID_X && y < GRID_Y && z < GRID_Z) begin
               case (req_tuser)
                  CMD_WRITE: grid[cur_bank][cell_addr(x, y, z)] = req_tdata[3*POS_W +: CELL_W];
                  CMD_COMPUTE: begin
                     want = next_cell_state(x, y, z);
                     grid[~cur_bank][cell_addr(x, y, z)] = want.next;
                     expected_cells.push_back(want);
                  end
                  default: ;
               endcase
            end
         end
      end
      mismatches  <= fail_total;
      outstanding <= expected_cells.size();
   end

endmodule

/* tb/tb.sv */
// Top of the testbench: stimulus, configuration phases and verdict for the cell engine.
`timescale 1ns / 1ps

module tb;
   import tacu_pkg::*;

   localparam int GRID_X       = 32;
   localparam int GRID_Y       = 32;
   localparam int GRID_Z       = 32;
   localparam int GRID_CELLS   = GRID_X * GRID_Y * GRID_Z;
   localparam int ITEMS        = 1300;
   localparam int NUM_PHASES   = 9;
   localparam int FIXED_PHASES = 5;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // pos_x [4:0], pos_y [9:5], pos_z [14:10], cell_value [17:15], zero [23:18]
   logic [23:0]           req_tdata  = '0;
   // cmd [1:0]
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // next_value [2:0], count_lower [7:3], count_same [12:8], zero [15:13]
   logic [15:0]           rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   int mismatches;
   int outstanding;

   // Stimulus-side view of which cells hold a value, so that no unwritten cell is read.
   bit filled [2][GRID_CELLS];
   bit live_bank = 1'b0;
   bit calm      = 1'b0;
   int sent      = 0;
   int req_quiet = 0;

   toroidal_3d_automaton_cell_update #(
      .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)
   ) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   cell_update_checker #(
      .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)
   ) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Result side: random stall bursts with quiet stretches in between.
   initial begin
      int hold;
      int quiet;
      hold = 0;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (calm || quiet > 0) begin
            if (quiet > 0) quiet--;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 3) begin
            quiet = $urandom_range(40, 300);
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 10) begin
            hold = $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int cell_addr(input int x, input int y, input int z);
      return x + y * GRID_X + z * GRID_X * GRID_Y;
   endfunction

   function automatic bit nbhd_ready(input int x, input int y, input int z);
      int dx, dy, dz;
      for (dz = 0; dz < 3; dz++)
         for (dy = 0; dy < 3; dy++)
            for (dx = 0; dx < 3; dx++)
               if (!filled[live_bank][cell_addr((x + GRID_X - 1 + dx) % GRID_X,
                                                (y + GRID_Y - 1 + dy) % GRID_Y,
                                                (z + GRID_Z - 1 + dz) % GRID_Z)])
                  return 1'b0;
      return 1'b1;
   endfunction

   // Edges are favored so that the wrap on every axis is hit often.
   function automatic int pick_coord(input int size);
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 0;
      if (r < 30) return size - 1;
      return $urandom_range(0, size - 1);
   endfunction

   // Values cluster around one level so that the counts land near the thresholds.
   function automatic logic [CELL_W-1:0] pick_value(input logic [CELL_W-1:0] lvl,
                                                     input int dens);
      if ($urandom_range(0, 99) < dens) return lvl;
      case ($urandom_range(0, 3))
         0:       return lvl - 3'd1;
         1:       return '0;
         2:       return lvl + 3'd1;
         default: return CELL_W'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic send_item(input logic [1:0] cmd, input int x, input int y, input int z,
                            input int val);
      int gap;
      int addr;
      gap = 0;
      if (!calm) begin
         if (req_quiet > 0) req_quiet--;
         else if ($urandom_range(0, 99) < 4) req_quiet = $urandom_range(5, 40);
         else if ($urandom_range(0, 99) < 15) gap = $urandom_range(1, 18);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, CELL_W'(val), POS_W'(z), POS_W'(y), POS_W'(x)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      addr = cell_addr(x, y, z);
      if (cmd == CMD_WRITE) filled[live_bank][addr] = 1'b1;
      else if (cmd == CMD_COMPUTE) filled[~live_bank][addr] = 1'b1;
      else if (cmd == CMD_SWAP) live_bank = ~live_bank;
      if (cmd != CMD_UNUSED) sent++;
   endtask

   // Stop offering items and let the engine run dry.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [CELL_W-1:0] birth, input logic [COUNT_W-1:0] lo,
                                input logic [COUNT_W-1:0] hi);
      csr_index_type   order [3];
      logic [CSR_DATA_W-1:0] vals [3];
      int i;
      order[0] = CSR_BIRTH_LEVEL;
      order[1] = CSR_SURVIVE_MIN;
      order[2] = CSR_SURVIVE_MAX;
      vals[0]  = CSR_DATA_W'(birth);
      vals[1]  = lo;
      vals[2]  = hi;
      for (i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Corner cell with every axis wrapping: full same count, an empty cell with all
   // neighbours above the threshold, one odd neighbour, the unused code and two swaps.
   task automatic directed_checks();
      int dx, dy, dz;
      int cx, cy, cz;
      cx = GRID_X - 1;
      cy = 0;
      cz = GRID_Z - 1;
      for (dz = 0; dz < 3; dz++)
         for (dy = 0; dy < 3; dy++)
            for (dx = 0; dx < 3; dx++)
               send_item(CMD_WRITE, (cx + GRID_X - 1 + dx) % GRID_X,
                         (cy + GRID_Y - 1 + dy) % GRID_Y, (cz + GRID_Z - 1 + dz) % GRID_Z,
                         7);
      send_item(CMD_COMPUTE, cx, cy, cz, 0);
      send_item(CMD_WRITE, cx, cy, cz, 0);
      send_item(CMD_COMPUTE, cx, cy, cz, 7);
      send_item(CMD_WRITE, cx - 1, GRID_Y - 1, cz - 1, 6);
      send_item(CMD_WRITE, cx, cy, cz, 7);
      send_item(CMD_COMPUTE, cx, cy, cz, 5);
      send_item(CMD_UNUSED, 31, 31, 31, 7);
      send_item(CMD_SWAP, 31, 31, 31, 7);
      send_item(CMD_SWAP, 0, 0, 0, 0);
      send_item(CMD_COMPUTE, cx, cy, cz, 2);
   endtask

   // One well-formed sequence: fill a neighbourhood, compute its centre and a few cells
   // next to it whose neighbourhoods happen to be complete, and sometimes swap the banks.
   task automatic probe_region();
      int cx, cy, cz, px, py, pz;
      int dx, dy, dz, k, extra, dens, rewrite;
      logic [CELL_W-1:0] lvl;
      logic [CELL_W-1:0] v;
      cx = pick_coord(GRID_X);
      cy = pick_coord(GRID_Y);
      cz = pick_coord(GRID_Z);
      lvl = CELL_W'($urandom_range(0, 7));
      dens = $urandom_range(0, 100);
      rewrite = $urandom_range(0, 100);
      for (dz = 0; dz < 3; dz++)
         for (dy = 0; dy < 3; dy++)
            for (dx = 0; dx < 3; dx++) begin
               px = (cx + GRID_X - 1 + dx) % GRID_X;
               py = (cy + GRID_Y - 1 + dy) % GRID_Y;
               pz = (cz + GRID_Z - 1 + dz) % GRID_Z;
               if (!filled[live_bank][cell_addr(px, py, pz)]
                   || $urandom_range(0, 99) < rewrite) begin
                  if (dx == 1 && dy == 1 && dz == 1 && $urandom_range(0, 99) < 35) v = '0;
                  else v = pick_value(lvl, dens);
                  send_item(CMD_WRITE, px, py, pz, int'(v));
               end
            end
      send_item(CMD_COMPUTE, cx, cy, cz, $urandom_range(0, 7));
      extra = $urandom_range(0, 3);
      for (k = 0; k < extra; k++) begin
         px = cx;
         py = cy;
         pz = cz;
         case ($urandom_range(0, 2))
            0:       px = (cx + ($urandom_range(0, 1) ? 1 : GRID_X - 1)) % GRID_X;
            1:       py = (cy + ($urandom_range(0, 1) ? 1 : GRID_Y - 1)) % GRID_Y;
            default: pz = (cz + ($urandom_range(0, 1) ? 1 : GRID_Z - 1)) % GRID_Z;
         endcase
         if (nbhd_ready(px, py, pz)) send_item(CMD_COMPUTE, px, py, pz, $urandom_range(0, 7));
      end
      if ($urandom_range(0, 99) < 15)
         send_item(CMD_SWAP, $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 7));
   endtask

   initial begin
      int phase;
      int phase_end;
      int r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_checks();
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            settle();
            case (phase)
               1: load_settings(3'd0, 5'd0, NBR_COUNT);
               2: load_settings(3'd7, NBR_COUNT, NBR_COUNT);
               3: load_settings(3'd1, 5'd10, 5'd5);   // empty survive range
               4: load_settings(3'd3, 5'd0, 5'd0);
               5: load_settings(3'd2, 5'd1, 5'd3);
               default: load_settings(CELL_W'($urandom_range(0, 7)),
                                      COUNT_W'($urandom_range(0, NBR_COUNT)),
                                      COUNT_W'($urandom_range(0, NBR_COUNT)));
            endcase
         end
         if (phase == NUM_PHASES - 1) calm <= 1'b1;
         phase_end = (phase + 1) * ITEMS / NUM_PHASES;
         while (sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 6)
               send_item(CMD_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom_range(0, 7));
            else if (r < 10)
               send_item(CMD_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom_range(0, 7));
            else if (r < 12)
               send_item(CMD_SWAP, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom_range(0, 7));
            probe_region();
         end
      end
      settle();
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/tacu_pkg.sv
hdl/tacu_ram.sv
hdl/toroidal_3d_automaton_cell_update.sv
tb/cell_update_checker.sv
tb/tb.sv
